// ===== hw/rtl/bgre_pkg.sv =====
// Shared constants, types and command/status bundles for the battery gauge core.
`default_nettype none

package bgre_pkg;

    localparam int HISTORY_DEPTH = 24;

    localparam int PCT_W     = 7;
    localparam int ADC_W     = 12;
    localparam int TIME_W    = 32;
    localparam int HOURS_W   = 12;
    localparam int IDX_W     = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W     = $clog2(2 * HISTORY_DEPTH);
    localparam int NUM_W     = $clog2(100 * (HISTORY_DEPTH - 1) + 1);
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int QUO_W     = (NUM_W > HOURS_W) ? NUM_W : HOURS_W;

    localparam int PROD_W    = 22;
    localparam int SCALED_W  = 10;
    localparam int RECIP_W   = 23;
    localparam int RECIP_SH  = 34;

    localparam logic [9:0]          PCT_GAIN   = 10'd550;
    localparam logic [RECIP_W-1:0]  PCT_RECIP  = 23'd4195329;
    localparam logic [SCALED_W-1:0] PCT_OFFSET = 10'd250;
    localparam logic [SCALED_W-1:0] PCT_MAX    = 10'd100;
    localparam logic [PCT_W:0]      HYST_MARGIN = 8'd5;
    localparam logic [QUO_W-1:0]    HOURS_MAX  = QUO_W'(4095);

    localparam logic [1:0] REG_LOW_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CHECK_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

    localparam logic [PCT_W-1:0]  RST_LOW_THRESHOLD  = 7'd20;
    localparam logic [TIME_W-1:0] RST_CHECK_INTERVAL = 32'd60000;
    localparam logic [TIME_W-1:0] RST_SAMPLE_PERIOD  = 32'd3600000;

    typedef struct packed {
        logic [PCT_W-1:0]  low_threshold;
        logic [TIME_W-1:0] check_interval_ms;
        logic [TIME_W-1:0] sample_period_ms;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic scale;
        logic percent;
        logic record;
        logic read;
        logic setup;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic check_due;
        logic est_valid;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_gauge_runtime_estimator_core.sv =====
// Top level of the battery gauge and runtime estimator core.
//
// Input channel s_*: one transaction per timestamped ADC sample (s_now_ms, s_adc_raw).
// A sample is checked only once check_interval_ms has elapsed since the last check;
// otherwise it is dropped in the check step and gives no result.
// A check gives one result transaction on m_*: percent, low warning, whether a history
// sample was stored, and the remaining-hours estimate.
// A check runs through the check, scale, percent, record, read and setup steps, then
// through the estimate divider when an estimate is formed (NUM_W quotient bits,
// one quotient bit per cycle), and ends in the output step. One transaction is in
// flight at a time, so a check occupies the block until its result is loaded into the
// output register; s_ready is high only between transactions.
// A finished result waits in the output register; a new sample is accepted and worked
// on meanwhile, and its result holds in the final step until the receiver takes the
// previous one.
// Reset (aresetn low, synchronous) clears timers, ring pointers, count, warning flag
// and the output valid; registers return to their defaults. The history ring needs no
// clearing: only entries written since reset are read.
// Configuration goes through the APB-style port at byte addresses 0, 4 and 8.
`default_nettype none

module battery_gauge_runtime_estimator_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bgre_pkg::TIME_W-1:0]  s_now_ms,
    input  wire logic [bgre_pkg::ADC_W-1:0]   s_adc_raw,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [bgre_pkg::PCT_W-1:0]   m_battery_percent,
    output logic                              m_low_warning,
    output logic                              m_sample_recorded,
    output logic                              m_estimate_valid,
    output logic      [bgre_pkg::HOURS_W-1:0] m_estimate_hours
);
    import bgre_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    bgre_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bgre_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .s_now_ms          (s_now_ms),
        .s_adc_raw         (s_adc_raw),
        .m_battery_percent (m_battery_percent),
        .m_low_warning     (m_low_warning),
        .m_sample_recorded (m_sample_recorded),
        .m_estimate_valid  (m_estimate_valid),
        .m_estimate_hours  (m_estimate_hours)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bgre_regs.sv =====
// APB-style configuration register file for the battery gauge core.
`default_nettype none

module bgre_regs (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output bgre_pkg::cfg_t          cfg
);
    import bgre_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_LOW_THRESHOLD:  cfg_next.low_threshold     = pwdata[PCT_W-1:0];
                REG_CHECK_INTERVAL: cfg_next.check_interval_ms = pwdata;
                REG_SAMPLE_PERIOD:  cfg_next.sample_period_ms  = pwdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LOW_THRESHOLD:  prdata = 32'(cfg_reg.low_threshold);
            REG_CHECK_INTERVAL: prdata = cfg_reg.check_interval_ms;
            REG_SAMPLE_PERIOD:  prdata = cfg_reg.sample_period_ms;
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_threshold     <= RST_LOW_THRESHOLD;
            cfg_reg.check_interval_ms <= RST_CHECK_INTERVAL;
            cfg_reg.sample_period_ms  <= RST_SAMPLE_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bgre_ctrl.sv =====
// Sequencing state machine and result handshake for the battery gauge core.
`default_nettype none

module bgre_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire bgre_pkg::status_t status,
    output bgre_pkg::cmd_t         cmd
);
    import bgre_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_CHECK   = 9'b000000010,
        ST_SCALE   = 9'b000000100,
        ST_PERCENT = 9'b000001000,
        ST_RECORD  = 9'b000010000,
        ST_READ    = 9'b000100000,
        ST_SETUP   = 9'b001000000,
        ST_DIVIDE  = 9'b010000000,
        ST_OUTPUT  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.check_due) begin
                    cmd.check  = 1'b1;
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_PERCENT;
            end
            ST_PERCENT: begin
                cmd.percent = 1'b1;
                state_next  = ST_RECORD;
            end
            ST_RECORD: begin
                cmd.record = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = status.est_valid ? ST_DIVIDE : ST_OUTPUT;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bgre_dpath.sv =====
// Datapath: timers, percent conversion, history ring, hysteresis and hours divider.
`default_nettype none

module bgre_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bgre_pkg::cfg_t              cfg,
    input  wire bgre_pkg::cmd_t              cmd,
    output bgre_pkg::status_t                status,
    input  wire logic [bgre_pkg::TIME_W-1:0] s_now_ms,
    input  wire logic [bgre_pkg::ADC_W-1:0]  s_adc_raw,
    output logic      [bgre_pkg::PCT_W-1:0]  m_battery_percent,
    output logic                             m_low_warning,
    output logic                             m_sample_recorded,
    output logic                             m_estimate_valid,
    output logic      [bgre_pkg::HOURS_W-1:0] m_estimate_hours
);
    import bgre_pkg::*;

    logic [PCT_W-1:0]     hist_mem [HISTORY_DEPTH];

    logic [TIME_W-1:0]    now_reg;
    logic [ADC_W-1:0]     raw_reg;
    logic [TIME_W-1:0]    last_check_reg;
    logic [TIME_W-1:0]    last_sample_reg;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [IDX_W-1:0]     wr_idx_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 warn_reg;
    logic                 warn_next;
    logic                 sample_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [PCT_W-1:0]     pct_reg;
    logic [PCT_W-1:0]     pct_next;
    logic [PCT_W-1:0]     old_rd_reg;
    logic [PCT_W-1:0]     new_rd_reg;
    logic                 est_valid_reg;
    logic [PCT_W-1:0]     den_reg;
    logic [PCT_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [TIME_W-1:0]    check_gap;
    logic [TIME_W-1:0]    sample_gap;
    logic                 sample_due;
    logic [RECIP_W+PROD_W-1:0] scale_prod;
    logic [SCALED_W-1:0]  scaled_diff;
    logic [SUM_W-1:0]     old_sum;
    logic [IDX_W-1:0]     old_idx;
    logic [IDX_W-1:0]     new_idx;
    logic [PCT_W+COUNT_W-1:0] num_full;
    logic [PCT_W:0]       trial;
    logic [QUO_W-1:0]     quo_ext;
    logic [HOURS_W-1:0]   hours_sat;

    assign check_gap  = now_reg - last_check_reg;
    assign sample_gap = now_reg - last_sample_reg;
    assign sample_due = (sample_gap >= cfg.sample_period_ms) || (last_sample_reg == '0);

    assign scale_prod = (RECIP_W+PROD_W)'(prod_reg) * (RECIP_W+PROD_W)'(PCT_RECIP);

    assign scaled_diff = scaled_reg - PCT_OFFSET;
    always_comb begin
        if (scaled_reg <= PCT_OFFSET) begin
            pct_next = '0;
        end else if (scaled_diff > PCT_MAX) begin
            pct_next = PCT_MAX[PCT_W-1:0];
        end else begin
            pct_next = scaled_diff[PCT_W-1:0];
        end
    end

    always_comb begin
        warn_next = warn_reg;
        if ({1'b0, pct_reg} <= {1'b0, cfg.low_threshold}) begin
            warn_next = 1'b1;
        end else if ({1'b0, pct_reg} > ({1'b0, cfg.low_threshold} + HYST_MARGIN)) begin
            warn_next = 1'b0;
        end
    end

    assign wr_idx_next = (wr_idx_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;

    assign old_sum = SUM_W'(wr_idx_reg) + SUM_W'(HISTORY_DEPTH) - SUM_W'(count_reg);
    assign old_idx = (old_sum >= SUM_W'(HISTORY_DEPTH)) ?
                     IDX_W'(old_sum - SUM_W'(HISTORY_DEPTH)) : old_sum[IDX_W-1:0];
    assign new_idx = (wr_idx_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1) : wr_idx_reg - 1'b1;

    assign num_full = (PCT_W+COUNT_W)'(pct_reg) * (PCT_W+COUNT_W)'(count_reg - 1'b1);
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};

    assign quo_ext   = QUO_W'(quo_reg);
    assign hours_sat = (quo_ext > HOURS_MAX) ? HOURS_MAX[HOURS_W-1:0] : quo_ext[HOURS_W-1:0];

    assign status.check_due = (check_gap >= cfg.check_interval_ms);
    assign status.est_valid = (count_reg >= COUNT_W'(2)) && (old_rd_reg > new_rd_reg);
    assign status.div_last  = (div_cnt_reg == DIV_CNT_W'(NUM_W - 1));

    always_ff @(posedge aclk) begin
        if (cmd.record && sample_reg) begin
            hist_mem[wr_idx_reg] <= pct_reg;
        end
        if (cmd.read) begin
            old_rd_reg <= hist_mem[old_idx];
            new_rd_reg <= hist_mem[new_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_check_reg  <= '0;
            last_sample_reg <= '0;
            wr_idx_reg      <= '0;
            count_reg       <= '0;
            warn_reg        <= 1'b0;
        end else begin
            if (cmd.check) begin
                last_check_reg <= now_reg;
            end
            if (cmd.record) begin
                warn_reg <= warn_next;
                if (sample_reg) begin
                    last_sample_reg <= now_reg;
                    wr_idx_reg      <= wr_idx_next;
                    if (count_reg < COUNT_W'(HISTORY_DEPTH)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg <= s_now_ms;
            raw_reg <= s_adc_raw;
        end
        if (cmd.check) begin
            sample_reg <= sample_due;
            prod_reg   <= PROD_W'(raw_reg) * PROD_W'(PCT_GAIN);
        end
        if (cmd.scale) begin
            scaled_reg <= scale_prod[RECIP_SH+SCALED_W-1:RECIP_SH];
        end
        if (cmd.percent) begin
            pct_reg <= pct_next;
        end
        if (cmd.setup) begin
            est_valid_reg <= status.est_valid;
            den_reg       <= old_rd_reg - new_rd_reg;
            rem_reg       <= '0;
            quo_reg       <= NUM_W'(num_full);
            div_cnt_reg   <= '0;
        end
        if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= PCT_W'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[PCT_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out) begin
            m_battery_percent <= pct_reg;
            m_low_warning     <= warn_reg;
            m_sample_recorded <= sample_reg;
            m_estimate_valid  <= est_valid_reg;
            m_estimate_hours  <= est_valid_reg ? hours_sat : '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bgre_checker.sv =====
// Port-level assertions for the battery gauge core, bound to the top level.
`default_nettype none

module bgre_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [bgre_pkg::PCT_W-1:0]   m_battery_percent,
    input wire logic                         m_low_warning,
    input wire logic                         m_sample_recorded,
    input wire logic                         m_estimate_valid,
    input wire logic [bgre_pkg::HOURS_W-1:0] m_estimate_hours
);
    import bgre_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_battery_percent)
            && $stable(m_low_warning) && $stable(m_sample_recorded)
            && $stable(m_estimate_valid) && $stable(m_estimate_hours))
        else $error("result transaction changed while stalled");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_battery_percent <= PCT_W'(100))
        else $error("battery percent above 100");

    a_hours_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_estimate_valid |-> m_estimate_hours == '0)
        else $error("hours reported without a valid estimate");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind battery_gauge_runtime_estimator_core bgre_checker u_checker (.*);

`default_nettype wire
